@@ hdl/ubx_ack_matcher_defines.svh @@
// assertion macros shared by the ubx acknowledge matcher checker
// no dependencies; expects clk and rst_n in the scope where a macro is used
`ifndef UBX_ACK_MATCHER_DEFINES_SVH
`define UBX_ACK_MATCHER_DEFINES_SVH

// same-cycle implication, inactive during reset
`define UBX_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, inactive during reset
`define UBX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/ubx_pkg.sv @@
// shared types, codes and the expected-frame function of the ubx acknowledge matcher
// no dependencies
package ubx_pkg;

    // operation codes of an input item
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // status codes of a result item
    localparam logic [1:0] STATUS_WAIT    = 2'd0;
    localparam logic [1:0] STATUS_ACK     = 2'd1;
    localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_ACK_CLASS     = 2'd0;
    localparam logic [1:0] CFG_ACK_MSG_ID    = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd2;

    // frame layout and reset values
    localparam logic [3:0]  FRAME_LEN     = 4'd10;
    localparam logic [15:0] TIMEOUT_RESET = 16'd3000;
    localparam logic [15:0] TICK_MAX      = 16'hFFFF;

    localparam logic [7:0] SYNC_1    = 8'hB5;
    localparam logic [7:0] SYNC_2    = 8'h62;
    localparam logic [7:0] CLASS_ACK = 8'h05;
    localparam logic [7:0] ID_ACK    = 8'h01;
    localparam logic [7:0] LEN_LO    = 8'h02;
    localparam logic [7:0] LEN_HI    = 8'h00;

    // fixed part of the fletcher sums over class, id and length bytes
    localparam logic [7:0] CK_A_BASE = CLASS_ACK + ID_ACK + LEN_LO + LEN_HI;
    localparam logic [7:0] CK_B_BASE = (CLASS_ACK * 8'd6) + (ID_ACK * 8'd5)
                                     + (LEN_LO * 8'd4) + (LEN_HI * 8'd3);

    // matcher phase, one-hot
    typedef enum logic [2:0] {
        PH_WAIT    = 3'b001,
        PH_ACK     = 3'b010,
        PH_TIMEOUT = 3'b100
    } phase_t;

    // expected byte at a frame position, zero past the end
    function automatic logic [7:0] expected_byte(
        input logic [3:0] pos,
        input logic [7:0] ack_class,
        input logic [7:0] ack_msg_id
    );
        logic [7:0] ck_a;
        logic [7:0] ck_b;
        ck_a = CK_A_BASE + ack_class + ack_msg_id;
        ck_b = CK_B_BASE + {ack_class[6:0], 1'b0} + ack_msg_id;
        case (pos)
            4'd0:    expected_byte = SYNC_1;
            4'd1:    expected_byte = SYNC_2;
            4'd2:    expected_byte = CLASS_ACK;
            4'd3:    expected_byte = ID_ACK;
            4'd4:    expected_byte = LEN_LO;
            4'd5:    expected_byte = LEN_HI;
            4'd6:    expected_byte = ack_class;
            4'd7:    expected_byte = ack_msg_id;
            4'd8:    expected_byte = ck_a;
            4'd9:    expected_byte = ck_b;
            default: expected_byte = 8'h00;
        endcase
    endfunction

endpackage

@@ hdl/ubx_ack_matcher.sv @@
// top level of the ubx acknowledge matcher
// depends on ubx_pkg
//
// Watches a received byte stream for one UBX ACK-ACK frame (B5 62 05 01 02 00, class, id,
// CK_A, CK_B) and reports acknowledged or timed out. Every input item (start, byte, tick)
// gives exactly one result item carrying the status and the count of frame bytes matched so
// far. An item is taken in every cycle and its result appears in the output register in the
// cycle after; the matcher state and the result register update at the same clock edge, so
// the only thing that holds off input is a result still waiting in the output register while
// out_ready is low. Configuration writes are taken at any time with cfg_ready tied high.
module ubx_ack_matcher (
    input  logic       clk,
    input  logic       rst_n,
    // input items
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] operation,
    input  logic [7:0] rx_byte,
    // result items
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic [3:0] match_position,
    // configuration writes
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [15:0] cfg_data
);

    logic [7:0]  ack_class_reg;
    logic [7:0]  ack_msg_id_reg;
    logic [15:0] timeout_ticks_reg;

    logic [3:0]        match_index_reg;
    logic [3:0]        match_index_next;
    logic [15:0]       elapsed_reg;
    logic [15:0]       elapsed_next;
    ubx_pkg::phase_t   phase_reg;
    ubx_pkg::phase_t   phase_next;

    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic [3:0]  position_reg;
    logic [1:0]  status_next;

    logic        in_accept;
    logic [7:0]  exp_byte;
    logic [15:0] elapsed_inc;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_class_reg     <= 8'd0;
            ack_msg_id_reg    <= 8'd0;
            timeout_ticks_reg <= ubx_pkg::TIMEOUT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                ubx_pkg::CFG_ACK_CLASS:     ack_class_reg     <= cfg_data[7:0];
                ubx_pkg::CFG_ACK_MSG_ID:    ack_msg_id_reg    <= cfg_data[7:0];
                ubx_pkg::CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // expected byte and saturating tick increment
    assign exp_byte    = ubx_pkg::expected_byte(match_index_reg, ack_class_reg, ack_msg_id_reg);
    assign elapsed_inc = (elapsed_reg == ubx_pkg::TICK_MAX) ? elapsed_reg : elapsed_reg + 16'd1;

    // next matcher state for the item at the input
    always_comb
    begin
        match_index_next = match_index_reg;
        elapsed_next     = elapsed_reg;
        phase_next       = phase_reg;
        case (operation)
            ubx_pkg::OP_START:
            begin
                match_index_next = 4'd0;
                elapsed_next     = 16'd0;
                phase_next       = ubx_pkg::PH_WAIT;
            end
            ubx_pkg::OP_BYTE:
            begin
                if (phase_reg == ubx_pkg::PH_WAIT && match_index_reg < ubx_pkg::FRAME_LEN)
                begin
                    // a mismatch restarts without rechecking against the first sync byte
                    if (rx_byte == exp_byte)
                    begin
                        match_index_next = match_index_reg + 4'd1;
                    end
                    else
                    begin
                        match_index_next = 4'd0;
                    end
                    if (match_index_next >= ubx_pkg::FRAME_LEN)
                    begin
                        phase_next = ubx_pkg::PH_ACK;
                    end
                end
            end
            ubx_pkg::OP_TICK:
            begin
                if (phase_reg == ubx_pkg::PH_WAIT)
                begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc > timeout_ticks_reg)
                    begin
                        phase_next = ubx_pkg::PH_TIMEOUT;
                    end
                end
            end
            default: ;
        endcase
    end

    // phase to status code
    always_comb
    begin
        unique case (phase_next)
            ubx_pkg::PH_WAIT:    status_next = ubx_pkg::STATUS_WAIT;
            ubx_pkg::PH_ACK:     status_next = ubx_pkg::STATUS_ACK;
            ubx_pkg::PH_TIMEOUT: status_next = ubx_pkg::STATUS_TIMEOUT;
            default:             status_next = ubx_pkg::STATUS_WAIT;
        endcase
    end

    // matcher state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_index_reg <= 4'd0;
            elapsed_reg     <= 16'd0;
            phase_reg       <= ubx_pkg::PH_WAIT;
        end
        else if (in_accept)
        begin
            match_index_reg <= match_index_next;
            elapsed_reg     <= elapsed_next;
            phase_reg       <= phase_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            status_reg   <= status_next;
            position_reg <= match_index_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign match_position = position_reg;

endmodule

@@ hdl/ubx_ack_matcher_chk.sv @@
// port-level checker for the ubx acknowledge matcher, bound to the top level
// depends on ubx_pkg and ubx_ack_matcher_defines.svh
`include "ubx_ack_matcher_defines.svh"

module ubx_ack_matcher_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] status,
    input logic [3:0] match_position
);

    // position never runs past the frame length
    `UBX_ASSERT_NOW(a_pos_range, out_valid, match_position <= ubx_pkg::FRAME_LEN, "match position past frame end")

    // acknowledged only with a full frame matched
    `UBX_ASSERT_NOW(a_ack_full, out_valid && status == ubx_pkg::STATUS_ACK, match_position == ubx_pkg::FRAME_LEN, "ack without full frame")

    // waiting never shows a complete frame
    `UBX_ASSERT_NOW(a_wait_partial, out_valid && status == ubx_pkg::STATUS_WAIT, match_position < ubx_pkg::FRAME_LEN, "waiting with full frame")

    // a stalled result holds
    `UBX_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(match_position), "stalled result changed")

endmodule

bind ubx_ack_matcher ubx_ack_matcher_chk u_ubx_chk (.*);

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// testbench for the ubx acknowledge matcher: directed and random items checked against a predictor
// depends on ubx_pkg and ubx_ack_matcher
module tb_top;
    import ubx_pkg::*;

    // codes that the package leaves unnamed
    localparam logic [1:0] OP_NONE  = 2'd3;
    localparam logic [1:0] CFG_NONE = 2'd3;

    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned RANDOM_ITEMS = 1150;
    localparam int unsigned PRINT_LIMIT  = 40;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
    } rx_item_t;

    typedef struct packed {
        logic [1:0] state;
        logic [3:0] position;
    } ack_report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  operation = OP_START;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [3:0]  match_position;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_ACK_CLASS;
    logic [15:0] cfg_data = 16'h0000;

    // register copies, written only while the block is idle
    logic [7:0]  want_class = 8'h00;
    logic [7:0]  want_id = 8'h00;
    logic [15:0] tick_limit = TIMEOUT_RESET;

    // predicted matcher state
    logic [3:0]  frame_pos = 4'd0;
    logic [15:0] tick_count = 16'd0;
    logic [1:0]  ack_state = STATUS_WAIT;

    rx_item_t    pending_items[$];
    ack_report_t expected_reports[$];
    rx_item_t    next_item;
    ack_report_t oldest_report;

    int unsigned queued_count = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_gap = 0;
    int unsigned recv_stall = 0;
    bit          steady_flow = 1'b0;

    ubx_ack_matcher i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .match_position (match_position),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // expected frame byte for the current class and id, fletcher sums over bytes 2 to 7
    function automatic logic [7:0] frame_byte(input logic [3:0] pos);
        logic [7:0] frame [10];
        logic [7:0] run_a;
        logic [7:0] run_b;
        frame[0] = SYNC_1;
        frame[1] = SYNC_2;
        frame[2] = CLASS_ACK;
        frame[3] = ID_ACK;
        frame[4] = LEN_LO;
        frame[5] = LEN_HI;
        frame[6] = want_class;
        frame[7] = want_id;
        run_a = 8'h00;
        run_b = 8'h00;
        for (int k = 2; k < 8; k++)
        begin
            run_a = run_a + frame[k];
            run_b = run_b + run_a;
        end
        frame[8] = run_a;
        frame[9] = run_b;
        if (pos >= FRAME_LEN)
            return 8'h00;
        return frame[pos];
    endfunction

    // idle length: mostly none or short, a few long, none in steady stretches
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (steady_flow || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // advance the predicted matcher by one accepted item and queue its report
    task automatic track_item(input logic [1:0] op, input logic [7:0] data);
        ack_report_t report;
        case (op)
            OP_START:
            begin
                frame_pos  = 4'd0;
                tick_count = 16'd0;
                ack_state  = STATUS_WAIT;
            end
            OP_BYTE:
            begin
                if (ack_state == STATUS_WAIT && frame_pos < FRAME_LEN)
                begin
                    // a mismatch drops back to zero without a second look at the sync byte
                    if (data == frame_byte(frame_pos))
                        frame_pos = frame_pos + 4'd1;
                    else
                        frame_pos = 4'd0;
                    if (frame_pos >= FRAME_LEN)
                        ack_state = STATUS_ACK;
                end
            end
            OP_TICK:
            begin
                if (ack_state == STATUS_WAIT)
                begin
                    if (tick_count != TICK_MAX)
                        tick_count = tick_count + 16'd1;
                    if (tick_count > tick_limit)
                        ack_state = STATUS_TIMEOUT;
                end
            end
            default:
            begin
            end
        endcase
        report.state    = ack_state;
        report.position = frame_pos;
        expected_reports.push_back(report);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < PRINT_LIMIT)
            $display("tb_top: %0t %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // input driver, predicts each item as it is accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            operation  <= OP_START;
            rx_byte    <= 8'h00;
            send_gap   <= 0;
            frame_pos  = 4'd0;
            tick_count = 16'd0;
            ack_state  = STATUS_WAIT;
        end
        else
        begin
            if (in_valid && in_ready)
                track_item(operation, rx_byte);
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    next_item = pending_items.pop_front();
                    in_valid  <= 1'b1;
                    operation <= next_item.op;
                    rx_byte   <= next_item.data;
                    send_gap  <= pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            recv_stall <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_reports.size() == 0)
                    report_mismatch("result with none expected, status", int'(status), -1);
                else
                begin
                    oldest_report = expected_reports.pop_front();
                    if (status !== oldest_report.state)
                        report_mismatch("status", int'(status), int'(oldest_report.state));
                    if (match_position !== oldest_report.position)
                        report_mismatch("match_position", int'(match_position),
                                        int'(oldest_report.position));
                end
            end
            if (recv_stall != 0)
            begin
                out_ready  <= 1'b0;
                recv_stall <= recv_stall - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 7) == 0)
                    recv_stall <= pick_gap();
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic add_item(input logic [1:0] op, input logic [7:0] data);
        rx_item_t item;
        item.op   = op;
        item.data = data;
        pending_items.push_back(item);
        queued_count++;
    endtask

    task automatic add_frame();
        for (int pos = 0; pos < FRAME_LEN; pos++)
            add_item(OP_BYTE, frame_byte(pos[3:0]));
    endtask

    // wait at a falling edge until every item is sent and every report has come back
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_reports.size() != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ACK_CLASS:     want_class = value[7:0];
            CFG_ACK_MSG_ID:    want_id = value[7:0];
            CFG_TIMEOUT_TICKS: tick_limit = value;
            default:
            begin
            end
        endcase
        @(negedge clk);
    endtask

    // a start in most sessions, some noise, a frame that may break, interleaved ticks
    task automatic add_session();
        logic [7:0] good;
        int unsigned roll;
        if ($urandom_range(0, 9) != 0)
            add_item(OP_START, 8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 3))
            add_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        for (int pos = 0; pos < FRAME_LEN; pos++)
        begin
            good = frame_byte(pos[3:0]);
            if ($urandom_range(0, 3) == 0)
                add_item(OP_TICK, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 24) == 0)
                add_item(OP_NONE, 8'($urandom_range(0, 255)));
            roll = $urandom_range(0, 39);
            if (roll == 0)
            begin
                add_item(OP_BYTE, SYNC_1);
                break;
            end
            else if (roll == 1)
            begin
                add_item(OP_BYTE, good ^ (8'h01 << $urandom_range(0, 7)));
                break;
            end
            add_item(OP_BYTE, good);
        end
        repeat ($urandom_range(0, 3))
        begin
            if ($urandom_range(0, 1) == 0)
                add_item(OP_TICK, 8'($urandom_range(0, 255)));
            else
                add_item(OP_BYTE, 8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        int unsigned random_start;
        int unsigned phase_end;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // before any start: unknown operation, tick, mismatch, then a frame at reset values
        add_item(OP_NONE, 8'hFF);
        add_item(OP_TICK, 8'h00);
        add_item(OP_BYTE, 8'h00);
        add_frame();
        // done state holds against bytes and ticks
        add_item(OP_BYTE, SYNC_1);
        add_item(OP_TICK, 8'hFF);
        add_item(OP_NONE, 8'h00);
        // a repeated sync byte resets and is not taken as a new first byte
        add_item(OP_START, 8'hFF);
        add_item(OP_BYTE, SYNC_1);
        add_item(OP_BYTE, SYNC_1);
        add_item(OP_BYTE, SYNC_2);
        add_item(OP_BYTE, 8'hFF);
        wait_idle();

        // extreme registers, an unused index, then an immediate timeout
        write_reg(CFG_ACK_CLASS, 16'hABFF);
        write_reg(CFG_ACK_MSG_ID, 16'h54FF);
        write_reg(CFG_TIMEOUT_TICKS, 16'h0000);
        write_reg(CFG_NONE, 16'hFFFF);
        add_item(OP_START, 8'h00);
        add_item(OP_TICK, 8'h00);
        add_item(OP_BYTE, SYNC_1);
        add_item(OP_START, 8'h00);
        add_frame();
        wait_idle();

        // frame completes on the last tick still inside the limit
        write_reg(CFG_TIMEOUT_TICKS, 16'd3);
        write_reg(CFG_ACK_CLASS, 16'h0006);
        write_reg(CFG_ACK_MSG_ID, 16'h0080);
        add_item(OP_START, 8'h00);
        repeat (3) add_item(OP_TICK, 8'h00);
        add_frame();
        add_item(OP_TICK, 8'h00);
        wait_idle();

        // lower the limit below the elapsed count while waiting
        write_reg(CFG_TIMEOUT_TICKS, 16'd40);
        add_item(OP_START, 8'h00);
        repeat (30) add_item(OP_TICK, 8'h00);
        wait_idle();
        write_reg(CFG_TIMEOUT_TICKS, 16'd20);
        add_item(OP_BYTE, SYNC_1);
        add_item(OP_TICK, 8'h00);
        wait_idle();

        // random phases, new register values between them, state carried across
        random_start = queued_count;
        while (queued_count < random_start + RANDOM_ITEMS)
        begin
            steady_flow = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 1) == 0)
                write_reg(CFG_ACK_CLASS, 16'($urandom_range(0, 16'hFFFF)));
            if ($urandom_range(0, 1) == 0)
                write_reg(CFG_ACK_MSG_ID, 16'($urandom_range(0, 16'hFFFF)));
            case ($urandom_range(0, 7))
                0: write_reg(CFG_TIMEOUT_TICKS, 16'h0000);
                1: write_reg(CFG_TIMEOUT_TICKS, 16'hFFFF);
                2: write_reg(CFG_TIMEOUT_TICKS, TIMEOUT_RESET);
                3: write_reg(CFG_TIMEOUT_TICKS, 16'($urandom_range(0, 16'hFFFF)));
                default: write_reg(CFG_TIMEOUT_TICKS, 16'($urandom_range(1, 40)));
            endcase
            phase_end = queued_count + $urandom_range(40, 120);
            while (queued_count < phase_end)
                add_session();
            wait_idle();
        end

        repeat (4) @(negedge clk);
        if (error_count == 0 && expected_reports.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
